>>> hw/rtl/banked_memory_and_port_decoder_assert.svh
// Assertion macros for the memory paging and port decoder.
// Define ASSERT_OFF to compile the checks out.
`ifndef BANKED_MEMORY_AND_PORT_DECODER_ASSERT_SVH
`define BANKED_MEMORY_AND_PORT_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

// Check held outside reset
`define BMPD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bmpd assertion failed");

// Check that also holds during and right after reset
`define BMPD_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bmpd reset assertion failed");

`else

`define BMPD_ASSERT(label, clk, rst, prop)
`define BMPD_ASSERT_RST(label, clk, prop)

`endif

`endif

>>> hw/rtl/bmpd_pkg.sv
package bmpd_pkg;

  // Bus access kind
  typedef enum logic [1:0] {
    REQ_MEM_RD = 2'd0,
    REQ_MEM_WR = 2'd1,
    REQ_IO_RD  = 2'd2,
    REQ_IO_WR  = 2'd3
  } req_t;

  // Memory segment (address bits 15..14)
  localparam logic [1:0] SEG_ROM    = 2'd0;
  localparam logic [1:0] SEG_SCREEN = 2'd1;
  localparam logic [1:0] SEG_FIXED  = 2'd2;

  localparam logic [2:0] PAGE_SCREEN = 3'd5;
  localparam logic [2:0] PAGE_FIXED  = 3'd2;

  // Port decode
  localparam logic [7:0] PORT_ULA    = 8'hFE;
  localparam logic [7:0] PORT_JOY    = 8'h1F;
  localparam logic [7:0] PORT_PAGING = 8'hFD;
  localparam logic [7:0] HIGH_MAIN   = 8'h7F;
  localparam logic [7:0] HIGH_EXT    = 8'h1F;
  localparam logic [7:0] FLOAT_SET   = 8'hE0;
  localparam logic [7:0] FLOAT_CLR   = 8'h40;
  localparam logic [7:0] FLOAT_BYTE  = FLOAT_SET & ~FLOAT_CLR;
  localparam int         EAR_BIT     = 6;

  localparam int         KEY_ROWS    = 8;
  localparam logic [2:0] BORDER_RST  = 3'd7;

  // Paging latches and ULA output levels
  typedef struct packed {
    logic [2:0] ram_bank;
    logic       rom_low;
    logic       rom_high;
    logic       screen;
    logic       lock;
    logic       mode;
    logic [2:0] border;
    logic       speaker;
    logic       mic;
  } latch_t;

  // Power-on latch values: border 7, all else 0
  localparam latch_t LATCH_RST = '{ram_bank: 3'd0,
                                   rom_low:  1'b0,
                                   rom_high: 1'b0,
                                   screen:   1'b0,
                                   lock:     1'b0,
                                   mode:     1'b0,
                                   border:   BORDER_RST,
                                   speaker:  1'b0,
                                   mic:      1'b0};

  // One input word
  typedef struct packed {
    req_t        req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [63:0] key_rows;
    logic [7:0]  joystick_byte;
    logic        ear_level;
  } item_t;

  // One result word
  typedef struct packed {
    logic        target_is_rom;
    logic [2:0]  target_page;
    logic [13:0] page_offset;
    logic        mem_write_enable;
    logic [7:0]  io_read_data;
    logic [2:0]  border_color;
    logic        speaker_level;
    logic        mic_level;
    logic        shadow_screen;
    logic        special_mode;
  } result_t;

endpackage

>>> hw/rtl/banked_memory_and_port_decoder.sv
// Channel   Handshake                Payload
// request   req_valid / req_ready    req_type address write_data key_rows
//                                    joystick_byte ear_level
// response  rsp_valid / rsp_ready    target_is_rom target_page page_offset
//                                    mem_write_enable io_read_data border_color
//                                    speaker_level mic_level shadow_screen
//                                    special_mode
//
// A word passes an input register, then one decode pass into the
// response register. One word per cycle is taken while the response side
// keeps up. Latches update when a word moves from the input register to the
// response register. Reset clears both valid flags and sets the latches to
// their power-on values (border 7, all else 0). A stalled response holds the
// input register; req_ready drops only while both stages are full and stalled.
`include "banked_memory_and_port_decoder_assert.svh"

module banked_memory_and_port_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [63:0] key_rows,
  input  logic [7:0]  joystick_byte,
  input  logic        ear_level,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic        target_is_rom,
  output logic [2:0]  target_page,
  output logic [13:0] page_offset,
  output logic        mem_write_enable,
  output logic [7:0]  io_read_data,
  output logic [2:0]  border_color,
  output logic        speaker_level,
  output logic        mic_level,
  output logic        shadow_screen,
  output logic        special_mode
);
  import bmpd_pkg::*;

  logic    in_valid;
  item_t   in_item;
  latch_t  latch;
  latch_t  latch_next;
  result_t result_next;
  result_t result;
  logic    advance;

  // Move the held word on when the response slot is free or being drained
  assign advance   = in_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req_ready) begin
      in_valid <= req_valid;
    end
    if (req_valid && req_ready) begin
      in_item <= '{req_type:      req_t'(req_type),
                   address:       address,
                   write_data:    write_data,
                   key_rows:      key_rows,
                   joystick_byte: joystick_byte,
                   ear_level:     ear_level};
    end
  end

  bmpd_decode u_decode (
    .item       (in_item),
    .latch      (latch),
    .latch_next (latch_next),
    .result     (result_next)
  );

  // Paging latches
  always_ff @(posedge clk) begin
    if (rst) begin
      latch <= LATCH_RST;
    end else if (advance) begin
      latch <= latch_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || rsp_ready) begin
      rsp_valid <= in_valid;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign target_is_rom    = result.target_is_rom;
  assign target_page      = result.target_page;
  assign page_offset      = result.page_offset;
  assign mem_write_enable = result.mem_write_enable;
  assign io_read_data     = result.io_read_data;
  assign border_color     = result.border_color;
  assign speaker_level    = result.speaker_level;
  assign mic_level        = result.mic_level;
  assign shadow_screen    = result.shadow_screen;
  assign special_mode     = result.special_mode;

  // ROM is never written
  `BMPD_ASSERT(a_no_rom_write, clk, rst, rsp_valid && mem_write_enable |-> !target_is_rom)
  // Once locked, the main paging latch stays locked until reset
  `BMPD_ASSERT(a_lock_sticky, clk, rst, latch.lock |=> latch.lock)
  // A word in flight to a stalled response slot holds back the input side
  `BMPD_ASSERT(a_stall_backpressure, clk, rst, in_valid && rsp_valid && !rsp_ready |-> !req_ready)
  // Reset empties both stages
  `BMPD_ASSERT_RST(a_reset_empty, clk, rst |=> !in_valid && !rsp_valid)

endmodule

>>> hw/rtl/bmpd_decode.sv
module bmpd_decode (
  input  bmpd_pkg::item_t   item,
  input  bmpd_pkg::latch_t  latch,
  output bmpd_pkg::latch_t  latch_next,
  output bmpd_pkg::result_t result
);
  import bmpd_pkg::*;

  logic [7:0] lo;
  logic [7:0] hi;
  logic [7:0] key_byte;
  logic       is_mem;
  logic       is_rom;
  logic [2:0] page;

  assign lo     = item.address[7:0];
  assign hi     = item.address[15:8];
  assign is_mem = (item.req_type == REQ_MEM_RD) || (item.req_type == REQ_MEM_WR);
  assign is_rom = (item.address[15:14] == SEG_ROM);

  // Page select from the top two address bits
  always_comb begin
    case (item.address[15:14])
      SEG_ROM:    page = {1'b0, latch.rom_high, latch.rom_low};
      SEG_SCREEN: page = PAGE_SCREEN;
      SEG_FIXED:  page = PAGE_FIXED;
      default:    page = latch.ram_bank;
    endcase
  end

  // Keyboard port: AND of rows whose high address line is low; bit 6 is cleared when ear is low and the high byte is FE
  always_comb begin
    key_byte = 8'hFF;
    if (hi == PORT_ULA && !item.ear_level) begin
      key_byte[EAR_BIT] = 1'b0;
    end
    for (int i = 0; i < KEY_ROWS; i++) begin
      if (!hi[i]) begin
        key_byte = key_byte & item.key_rows[8*i +: 8];
      end
    end
  end

  // Latch updates on io writes
  always_comb begin
    latch_next = latch;
    if (item.req_type == REQ_IO_WR) begin
      if (lo == PORT_ULA) begin
        latch_next.border  = item.write_data[2:0];
        latch_next.speaker = item.write_data[4];
        latch_next.mic     = item.write_data[3];
      end else if (lo == PORT_PAGING) begin
        if (hi == HIGH_MAIN) begin
          if (!latch.lock) begin
            latch_next.lock     = item.write_data[5];
            latch_next.rom_low  = item.write_data[4];
            latch_next.screen   = item.write_data[3];
            latch_next.ram_bank = item.write_data[2:0];
          end
        end else if (hi == HIGH_EXT) begin
          latch_next.mode     = item.write_data[0];
          latch_next.rom_high = item.write_data[2];
        end
      end
    end
  end

  // Result word; status fields show the latches after this access
  always_comb begin
    result                  = '0;
    result.target_is_rom    = is_mem && is_rom;
    result.target_page      = is_mem ? page : 3'd0;
    result.page_offset      = is_mem ? item.address[13:0] : 14'd0;
    result.mem_write_enable = (item.req_type == REQ_MEM_WR) && !is_rom;
    if (item.req_type == REQ_IO_RD) begin
      if (lo == PORT_ULA) begin
        result.io_read_data = key_byte;
      end else if (lo == PORT_JOY) begin
        result.io_read_data = item.joystick_byte;
      end else begin
        result.io_read_data = FLOAT_BYTE;
      end
    end
    result.border_color  = latch_next.border;
    result.speaker_level = latch_next.speaker;
    result.mic_level     = latch_next.mic;
    result.shadow_screen = latch_next.screen;
    result.special_mode  = latch_next.mode;
  end

endmodule
